>>> rtl/swn_pkg.sv
`default_nettype none

package swn_pkg;

    // vertex layout
    localparam int LANES              = 4;
    localparam int WEIGHTS_PER_VERTEX = 4;
    localparam int USED_LANES         = (WEIGHTS_PER_VERTEX < LANES) ? WEIGHTS_PER_VERTEX
                                                                    : LANES;

    // widths
    localparam int IN_W   = 18;                    // signed Q2.16 in
    localparam int W_W    = 17;                    // unsigned Q1.16 out / clamped weight
    localparam int SUM_W  = W_W + $clog2(LANES);   // clamped sum
    localparam int REM_W  = SUM_W + 1;             // divider partial remainder
    localparam int QUO_W  = 17;                    // quotient, at most 1.0
    localparam int TOL_W  = 8;

    // pipeline depth: front stage, one stage per quotient bit, output stage
    localparam int DIV_STAGES = QUO_W;
    localparam int NUM_STAGES = DIV_STAGES + 2;

    localparam logic [W_W-1:0]   ONE_Q16   = W_W'(65536);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    // per-vertex decision that rides beside the divider lanes
    typedef struct packed {
        logic clamped;   // some weight was negative
        logic norm;      // sum out of tolerance
        logic zero;      // clamped sum is zero
    } t_flags;

endpackage

`default_nettype wire

>>> rtl/skin_weight_normalizer.sv
// Skinning weight normalizer.
// Input channel (i_in_valid / o_in_ready): one word per vertex, four signed
// Q2.16 weights. Output channel (o_out_valid / i_out_ready): four unsigned
// Q1.16 weights plus the adjusted flag. Both are valid/ready, a word moves
// when valid and ready are high at the same rising edge.
// Negative weights clamp to zero; if the clamped sum is off 1.0 by more than
// the tolerance register, each weight becomes floor(w * 65536 / sum), and a
// zero sum turns into 1.0 on the first weight.
// Pipeline: clamp/sum stage, 17 divider stages (one quotient bit each, four
// lanes side by side), one output stage. An accepted word passes the front
// register, the divider registers and the output register in turn. Throughput
// is one word per cycle while i_out_ready is high. Each stage moves on when
// it is empty or the stage after it moves, so bubbles close up and new words
// keep entering while a result waits. With i_out_ready low the pipe fills up,
// then o_in_ready drops; the output word holds steady until taken.
// Reset (synchronous, active low) empties the pipe and sets the tolerance
// to 1 LSB. Write the tolerance (i_cfg_we) only while the pipe is empty.
`default_nettype none

module skin_weight_normalizer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [swn_pkg::TOL_W-1:0]           i_cfg_wdata,
    // input words
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [swn_pkg::IN_W-1:0]     i_weight_in_0,
    input  wire logic signed [swn_pkg::IN_W-1:0]     i_weight_in_1,
    input  wire logic signed [swn_pkg::IN_W-1:0]     i_weight_in_2,
    input  wire logic signed [swn_pkg::IN_W-1:0]     i_weight_in_3,
    // output words
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [swn_pkg::W_W-1:0]             o_weight_out_0,
    output logic      [swn_pkg::W_W-1:0]             o_weight_out_1,
    output logic      [swn_pkg::W_W-1:0]             o_weight_out_2,
    output logic      [swn_pkg::W_W-1:0]             o_weight_out_3,
    output logic                                     o_adjusted
);

    localparam int NS = swn_pkg::NUM_STAGES;
    localparam int DS = swn_pkg::DIV_STAGES;

    // tolerance register
    logic [swn_pkg::TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= swn_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // stage 0 = front, 1..DS = divider, NS-1 = output register
    logic [NS-1:0] r_valid;
    logic [NS-1:0] n_valid;
    logic [NS-1:0] en;

    // a stage may load when the output is taken or any stage from it on is empty
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            en[k] = i_out_ready || !(&(r_valid | NS'((1 << k) - 1)));
        end
    end

    always_comb begin
        n_valid[0] = en[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < NS; k++) begin
            n_valid[k] = en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_valid[NS-1];

    // clamp and sum
    logic signed [swn_pkg::IN_W-1:0]  weight_in [swn_pkg::LANES];
    logic        [swn_pkg::W_W-1:0]   front_w   [swn_pkg::LANES];
    logic        [swn_pkg::SUM_W-1:0] front_sum;
    logic                             front_clamped;

    assign weight_in[0] = i_weight_in_0;
    assign weight_in[1] = i_weight_in_1;
    assign weight_in[2] = i_weight_in_2;
    assign weight_in[3] = i_weight_in_3;

    swn_front u_front (
        .i_clk     (i_clk),
        .i_en      (en[0]),
        .i_weight  (weight_in),
        .o_w       (front_w),
        .o_sum     (front_sum),
        .o_clamped (front_clamped)
    );

    // tolerance check, done alongside the first divider stage
    logic [swn_pkg::SUM_W-1:0] dev;
    swn_pkg::t_flags           flags_in;
    swn_pkg::t_flags           r_flags [DS];

    always_comb begin
        if (front_sum >= swn_pkg::SUM_W'(swn_pkg::ONE_Q16)) begin
            dev = front_sum - swn_pkg::SUM_W'(swn_pkg::ONE_Q16);
        end else begin
            dev = swn_pkg::SUM_W'(swn_pkg::ONE_Q16) - front_sum;
        end
        flags_in.clamped = front_clamped;
        flags_in.norm    = (dev > swn_pkg::SUM_W'(r_tol));
        flags_in.zero    = (front_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DS; s++) begin
            if (en[s+1]) begin
                r_flags[s] <= (s == 0) ? flags_in : r_flags[(s == 0) ? 0 : s-1];
            end
        end
    end

    // divider lanes
    logic [swn_pkg::QUO_W-1:0] lane_quo [swn_pkg::LANES];
    logic [swn_pkg::W_W-1:0]   lane_w   [swn_pkg::LANES];

    for (genvar i = 0; i < swn_pkg::LANES; i++) begin : g_lane
        swn_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en[DS:1]),
            .i_w   (front_w[i]),
            .i_div (front_sum),
            .o_quo (lane_quo[i]),
            .o_w   (lane_w[i])
        );
    end

    // output stage
    logic [swn_pkg::W_W-1:0] weight_out [swn_pkg::LANES];

    swn_merge u_merge (
        .i_clk      (i_clk),
        .i_en       (en[NS-1]),
        .i_flags    (r_flags[DS-1]),
        .i_quo      (lane_quo),
        .i_w        (lane_w),
        .o_weight   (weight_out),
        .o_adjusted (o_adjusted)
    );

    assign o_weight_out_0 = weight_out[0];
    assign o_weight_out_1 = weight_out[1];
    assign o_weight_out_2 = weight_out[2];
    assign o_weight_out_3 = weight_out[3];

endmodule

`default_nettype wire

>>> rtl/swn_front.sv
`default_nettype none

// Clamp negative weights and add up the clamped set; one register stage.
module swn_front (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [swn_pkg::IN_W-1:0]        i_weight [swn_pkg::LANES],
    output logic             [swn_pkg::W_W-1:0]         o_w      [swn_pkg::LANES],
    output logic             [swn_pkg::SUM_W-1:0]       o_sum,
    output logic                                        o_clamped
);

    logic [swn_pkg::W_W-1:0]   n_w [swn_pkg::LANES];
    logic [swn_pkg::SUM_W-1:0] n_sum;
    logic                      n_clamped;
    logic [swn_pkg::W_W-1:0]   r_w [swn_pkg::LANES];
    logic [swn_pkg::SUM_W-1:0] r_sum;
    logic                      r_clamped;

    always_comb begin
        n_sum     = '0;
        n_clamped = 1'b0;
        for (int i = 0; i < swn_pkg::LANES; i++) begin
            if (i < swn_pkg::USED_LANES && !i_weight[i][swn_pkg::IN_W-1]) begin
                n_w[i] = i_weight[i][swn_pkg::W_W-1:0];
            end else begin
                n_w[i] = '0;
            end
            if (i < swn_pkg::USED_LANES && i_weight[i][swn_pkg::IN_W-1]) begin
                n_clamped = 1'b1;
            end
            n_sum = n_sum + swn_pkg::SUM_W'(n_w[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w       <= n_w;
            r_sum     <= n_sum;
            r_clamped <= n_clamped;
        end
    end

    assign o_w       = r_w;
    assign o_sum     = r_sum;
    assign o_clamped = r_clamped;

endmodule

`default_nettype wire

>>> rtl/swn_div_lane.sv
`default_nettype none

// One weight lane: restoring divider, one quotient bit per stage.
// Computes floor(w * 2^16 / d) for w <= d; the unscaled weight rides along.
module swn_div_lane (
    input  wire logic                                i_clk,
    input  wire logic [swn_pkg::DIV_STAGES-1:0]      i_en,
    input  wire logic [swn_pkg::W_W-1:0]             i_w,
    input  wire logic [swn_pkg::SUM_W-1:0]           i_div,
    output logic      [swn_pkg::QUO_W-1:0]           o_quo,
    output logic      [swn_pkg::W_W-1:0]             o_w
);

    // last stage keeps no remainder or divisor
    logic [swn_pkg::REM_W-1:0] r_rem [swn_pkg::DIV_STAGES-1];
    logic [swn_pkg::SUM_W-1:0] r_div [swn_pkg::DIV_STAGES-1];
    logic [swn_pkg::QUO_W-1:0] r_quo [swn_pkg::DIV_STAGES];
    logic [swn_pkg::W_W-1:0]   r_w   [swn_pkg::DIV_STAGES];

    for (genvar s = 0; s < swn_pkg::DIV_STAGES; s++) begin : g_st
        logic [swn_pkg::REM_W-1:0] trial;
        logic [swn_pkg::SUM_W-1:0] d_in;
        logic [swn_pkg::QUO_W-1:0] q_in;
        logic [swn_pkg::QUO_W-1:0] q_nxt;
        logic [swn_pkg::W_W-1:0]   w_in;
        logic                      ge;

        if (s == 0) begin : g_first
            // top quotient bit: w itself against d (set only when w == d)
            assign trial = swn_pkg::REM_W'(i_w);
            assign d_in  = i_div;
            assign q_in  = '0;
            assign w_in  = i_w;
        end else begin : g_next
            assign trial = {r_rem[s-1][swn_pkg::REM_W-2:0], 1'b0};
            assign d_in  = r_div[s-1];
            assign q_in  = r_quo[s-1];
            assign w_in  = r_w[s-1];
        end

        assign ge    = (trial >= swn_pkg::REM_W'(d_in));
        assign q_nxt = q_in | (swn_pkg::QUO_W'(ge) << (swn_pkg::QUO_W-1-s));

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_quo[s] <= q_nxt;
                r_w[s]   <= w_in;
            end
        end

        if (s < swn_pkg::DIV_STAGES - 1) begin : g_keep
            logic [swn_pkg::REM_W-1:0] diff;

            assign diff = trial - swn_pkg::REM_W'(d_in);

            always_ff @(posedge i_clk) begin
                if (i_en[s]) begin
                    r_rem[s] <= ge ? diff : trial;
                    r_div[s] <= d_in;
                end
            end
        end
    end

    assign o_quo = r_quo[swn_pkg::DIV_STAGES-1];
    assign o_w   = r_w[swn_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/swn_merge.sv
`default_nettype none

// Output stage: picks quotient, unscaled weight or the zero-sum fallback.
module swn_merge (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire swn_pkg::t_flags                  i_flags,
    input  wire logic [swn_pkg::QUO_W-1:0]        i_quo    [swn_pkg::LANES],
    input  wire logic [swn_pkg::W_W-1:0]          i_w      [swn_pkg::LANES],
    output logic      [swn_pkg::W_W-1:0]          o_weight [swn_pkg::LANES],
    output logic                                  o_adjusted
);

    logic [swn_pkg::W_W-1:0] n_weight [swn_pkg::LANES];
    logic [swn_pkg::W_W-1:0] r_weight [swn_pkg::LANES];
    logic                    r_adjusted;

    always_comb begin
        for (int i = 0; i < swn_pkg::LANES; i++) begin
            if (i_flags.zero) begin
                n_weight[i] = (i == 0) ? swn_pkg::ONE_Q16 : i_w[i];
            end else if (i_flags.norm) begin
                n_weight[i] = swn_pkg::W_W'(i_quo[i]);
            end else begin
                n_weight[i] = i_w[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_weight   <= n_weight;
            r_adjusted <= i_flags.clamped | i_flags.norm;
        end
    end

    assign o_weight   = r_weight;
    assign o_adjusted = r_adjusted;

endmodule

`default_nettype wire

>>> rtl/swn_checker.sv
`default_nettype none

module swn_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    input  wire logic [swn_pkg::W_W-1:0]             o_weight_out_0,
    input  wire logic [swn_pkg::W_W-1:0]             o_weight_out_1,
    input  wire logic [swn_pkg::W_W-1:0]             o_weight_out_2,
    input  wire logic [swn_pkg::W_W-1:0]             o_weight_out_3,
    input  wire logic                                o_adjusted
);

    localparam logic [swn_pkg::SUM_W-1:0] MAX_TOL  = swn_pkg::SUM_W'(255);
    localparam logic [swn_pkg::SUM_W-1:0] ONE_SUM  = swn_pkg::SUM_W'(swn_pkg::ONE_Q16);

    logic [swn_pkg::SUM_W-1:0] out_sum;

    assign out_sum = swn_pkg::SUM_W'(o_weight_out_0) + swn_pkg::SUM_W'(o_weight_out_1)
                   + swn_pkg::SUM_W'(o_weight_out_2) + swn_pkg::SUM_W'(o_weight_out_3);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_weight_out_0)
            && $stable(o_weight_out_1) && $stable(o_weight_out_2)
            && $stable(o_weight_out_3) && $stable(o_adjusted))
        else $error("stalled output word changed");

    // untouched words already sum to one within the largest tolerance
    a_unadjusted_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_adjusted |->
            (out_sum + MAX_TOL >= ONE_SUM) && (out_sum <= ONE_SUM + MAX_TOL))
        else $error("unadjusted word does not sum to one");

    // in an adjusted word, no single weight exceeds the largest in-tolerance sum
    a_weight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_adjusted |->
            (swn_pkg::SUM_W'(o_weight_out_0) <= ONE_SUM + MAX_TOL)
            && (swn_pkg::SUM_W'(o_weight_out_1) <= ONE_SUM + MAX_TOL)
            && (swn_pkg::SUM_W'(o_weight_out_2) <= ONE_SUM + MAX_TOL)
            && (swn_pkg::SUM_W'(o_weight_out_3) <= ONE_SUM + MAX_TOL))
        else $error("adjusted weight out of range");

endmodule

bind skin_weight_normalizer swn_checker u_swn_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // one vertex as it goes in: four raw signed Q2.16 lanes, lane 0 in [0]
    typedef logic [3:0][swn_pkg::IN_W-1:0] t_vtx;

    // one result word as it comes out
    typedef struct packed {
        logic [3:0][swn_pkg::W_W-1:0] w;
        logic                         adj;
    } t_norm_res;

    // shapes the random vertices are drawn from
    typedef enum int {
        SHAPE_NEAR_ONE,       // clamped sum close to 1.0, lands near the tolerance edge
        SHAPE_NEAR_ONE_NEG,   // same, with one lane forced negative
        SHAPE_FULL_RANGE,     // every bit of every lane random
        SHAPE_TINY,           // small magnitudes, both signs
        SHAPE_VOID,           // nothing positive: clamped sum is zero
        SHAPE_EXTREMES        // lanes taken from the corner values
    } t_shape;

    // directed table columns: w0..w3, how the row is checked, expected w0..w3, adj
    localparam int ROW_PREDICT = 0;
    localparam int ROW_TYPED   = 1;
    localparam int DIR_ROWS    = 23;
    localparam int ONE         = 65536;
    localparam int WMAX        = 131071;
    localparam int WMIN        = -131072;

    localparam logic [swn_pkg::TOL_W-1:0] TOL_AFTER_RESET = 8'd1;

    // rows below assume the tolerance right after reset (1 LSB)
    int dir_tab [DIR_ROWS][10] = '{
        // zero sum: first lane becomes 1.0
        '{0,     0,     0,     0,     ROW_TYPED,   ONE,   0,     0,     0,     1},
        // already exactly one
        '{ONE,   0,     0,     0,     ROW_TYPED,   ONE,   0,     0,     0,     0},
        '{16384, 16384, 16384, 16384, ROW_TYPED,   16384, 16384, 16384, 16384, 0},
        // deviation equal to tolerance: left alone
        '{65537, 0,     0,     0,     ROW_TYPED,   65537, 0,     0,     0,     0},
        '{0,     0,     0,     65535, ROW_TYPED,   0,     0,     0,     65535, 0},
        // one LSB past tolerance on either side: rescaled
        '{65538, 0,     0,     0,     ROW_TYPED,   ONE,   0,     0,     0,     1},
        '{0,     65534, 0,     0,     ROW_TYPED,   0,     ONE,   0,     0,     1},
        // all lanes at the top
        '{WMAX,  WMAX,  WMAX,  WMAX,  ROW_TYPED,   16384, 16384, 16384, 16384, 1},
        // all lanes at the bottom: everything clamps, zero sum
        '{WMIN,  WMIN,  WMIN,  WMIN,  ROW_TYPED,   ONE,   0,     0,     0,     1},
        // first row clamps only, sum in tolerance; the rest mix rescales, a zero sum and in-tolerance sums
        '{-1,    ONE,   0,     0,     ROW_TYPED,   0,     ONE,   0,     0,     1},
        '{WMAX,  0,     0,     0,     ROW_TYPED,   ONE,   0,     0,     0,     1},
        '{-1,    -1,    -1,    -1,    ROW_TYPED,   ONE,   0,     0,     0,     1},
        '{1,     0,     0,     0,     ROW_TYPED,   ONE,   0,     0,     0,     1},
        '{32768, 32768, 0,     0,     ROW_TYPED,   32768, 32768, 0,     0,     0},
        '{1,     1,     1,     1,     ROW_TYPED,   16384, 16384, 16384, 16384, 1},
        '{21845, 21845, 21846, 0,     ROW_TYPED,   21845, 21845, 21846, 0,     0},
        '{65535, 1,     1,     0,     ROW_TYPED,   65535, 1,     1,     0,     0},
        '{WMAX,  1,     0,     0,     ROW_PREDICT, 0,     0,     0,     0,     0},
        '{100000, -5,   30000, 20000, ROW_PREDICT, 0,     0,     0,     0,     0},
        '{3,     5,     7,     11,    ROW_PREDICT, 0,     0,     0,     0,     0},
        '{WMAX,  WMAX,  WMIN,  0,     ROW_PREDICT, 0,     0,     0,     0,     0},
        '{0,     0,     WMIN,  WMAX,  ROW_PREDICT, 0,     0,     0,     0,     0},
        '{40000, 40000, 40000, 40000, ROW_PREDICT, 0,     0,     0,     0,     0}
    };

    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 286;
    localparam int SETTLE_CYC = 2 * swn_pkg::NUM_STAGES + 4;
    localparam int LONG_HOLD  = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [swn_pkg::TOL_W-1:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [swn_pkg::IN_W-1:0] i_weight_in_0 = '0;
    logic signed [swn_pkg::IN_W-1:0] i_weight_in_1 = '0;
    logic signed [swn_pkg::IN_W-1:0] i_weight_in_2 = '0;
    logic signed [swn_pkg::IN_W-1:0] i_weight_in_3 = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [swn_pkg::W_W-1:0] o_weight_out_0;
    logic [swn_pkg::W_W-1:0] o_weight_out_1;
    logic [swn_pkg::W_W-1:0] o_weight_out_2;
    logic [swn_pkg::W_W-1:0] o_weight_out_3;
    logic o_adjusted;

    skin_weight_normalizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_weight_in_0  (i_weight_in_0),
        .i_weight_in_1  (i_weight_in_1),
        .i_weight_in_2  (i_weight_in_2),
        .i_weight_in_3  (i_weight_in_3),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_weight_out_0 (o_weight_out_0),
        .o_weight_out_1 (o_weight_out_1),
        .o_weight_out_2 (o_weight_out_2),
        .o_weight_out_3 (o_weight_out_3),
        .o_adjusted     (o_adjusted)
    );

    // tolerance as the block holds it, updated on every register write
    logic [swn_pkg::TOL_W-1:0] tol_now = TOL_AFTER_RESET;
    // normalized words still owed by the block, oldest first
    t_norm_res owed_q [$];
    int err_cnt = 0;

    // sender and receiver pacing
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;
    int rx_taken = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the pipe hangs; far above the slowest legal run
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Clamp negatives, then rescale to floor(w * 1.0 / sum) when the sum is
    // off 1.0 by more than the tolerance. Zero sum puts 1.0 on lane 0.
    function automatic t_norm_res normalize_vertex(input t_vtx v,
                                                   input logic [swn_pkg::TOL_W-1:0] tol);
        t_norm_res r;
        longint unsigned cw [4];
        longint unsigned sum;
        longint unsigned dev;
        int used;
        r = '0;
        sum = '0;
        used = (swn_pkg::WEIGHTS_PER_VERTEX < 4) ? swn_pkg::WEIGHTS_PER_VERTEX : 4;
        for (int i = 0; i < 4; i++) begin
            cw[i] = '0;
            if (i < used) begin
                if (v[i][swn_pkg::IN_W-1]) begin
                    r.adj = 1'b1;
                end else begin
                    cw[i] = 64'(v[i]);
                end
                sum += cw[i];
            end
        end
        if (used > 0) begin
            dev = (sum >= 64'(ONE)) ? sum - 64'(ONE) : 64'(ONE) - sum;
            if (dev > 64'(tol)) begin
                r.adj = 1'b1;
                if (sum == 0) begin
                    cw[0] = 64'(ONE);
                end else begin
                    for (int i = 0; i < used; i++)
                        cw[i] = (cw[i] * 64'(ONE)) / sum;
                end
            end
        end
        for (int i = 0; i < 4; i++)
            r.w[i] = swn_pkg::W_W'(cw[i]);
        return r;
    endfunction

    function automatic logic [swn_pkg::IN_W-1:0] rand_negative();
        return swn_pkg::IN_W'(-int'($urandom_range(131072, 1)));
    endfunction

    // Random vertex; most start near 1.0 so both sides of the tolerance test get hit,
    // the rest cover the full field range, small values, zero sums and corner values.
    function automatic t_vtx random_vertex(input logic [swn_pkg::TOL_W-1:0] tol);
        t_vtx v;
        t_shape shape;
        int pick;
        int span;
        int total;
        int part [4];
        int rot;
        pick = $urandom_range(99, 0);
        if (pick < 45)      shape = SHAPE_NEAR_ONE;
        else if (pick < 60) shape = SHAPE_NEAR_ONE_NEG;
        else if (pick < 80) shape = SHAPE_FULL_RANGE;
        else if (pick < 88) shape = SHAPE_TINY;
        else if (pick < 93) shape = SHAPE_VOID;
        else                shape = SHAPE_EXTREMES;
        v = '0;
        case (shape)
            SHAPE_NEAR_ONE, SHAPE_NEAR_ONE_NEG: begin
                span = ($urandom_range(3, 0) == 0) ? 400 : int'(tol) + 2;
                total = ONE - span + int'($urandom_range(2 * span, 0));
                part[0] = $urandom_range(total, 0);
                part[1] = $urandom_range(total - part[0], 0);
                part[2] = $urandom_range(total - part[0] - part[1], 0);
                part[3] = total - part[0] - part[1] - part[2];
                rot = $urandom_range(3, 0);
                for (int i = 0; i < 4; i++)
                    v[(i + rot) % 4] = swn_pkg::IN_W'(part[i]);
                if (shape == SHAPE_NEAR_ONE_NEG)
                    v[$urandom_range(3, 0)] = rand_negative();
            end
            SHAPE_FULL_RANGE: begin
                for (int i = 0; i < 4; i++)
                    v[i] = swn_pkg::IN_W'($urandom);
            end
            SHAPE_TINY: begin
                for (int i = 0; i < 4; i++)
                    v[i] = swn_pkg::IN_W'(int'($urandom_range(16, 0)) - 4);
            end
            SHAPE_VOID: begin
                for (int i = 0; i < 4; i++)
                    v[i] = ($urandom_range(1, 0) == 1) ? '0 : rand_negative();
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    case ($urandom_range(5, 0))
                        0:       v[i] = swn_pkg::IN_W'(WMIN);
                        1:       v[i] = swn_pkg::IN_W'(-1);
                        2:       v[i] = '0;
                        3:       v[i] = swn_pkg::IN_W'(1);
                        4:       v[i] = swn_pkg::IN_W'(ONE);
                        default: v[i] = swn_pkg::IN_W'(WMAX);
                    endcase
                end
            end
        endcase
        return v;
    endfunction

    // idle cycles after a sent word: mostly none or short, now and then long,
    // with calm stretches of back-to-back words
    function automatic int tx_gap();
        int r;
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(3, 1);
        if (r < 88) return $urandom_range(10, 4);
        if (r < 95) begin
            tx_calm = $urandom_range(60, 15);
            return 0;
        end
        return $urandom_range(60, 20);
    endfunction

    // Offer one word and hold it until taken; the expectation is queued on
    // the edge the word moves. Valid stays up if no gap follows.
    task automatic send_word(input t_vtx v, input t_norm_res want);
        int gap;
        i_in_valid    <= 1'b1;
        i_weight_in_0 <= v[0];
        i_weight_in_1 <= v[1];
        i_weight_in_2 <= v[2];
        i_weight_in_3 <= v[3];
        do @(posedge i_clk); while (!o_in_ready);
        owed_q.push_back(want);
        gap = tx_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (owed_q.size() != 0) @(posedge i_clk);
    endtask

    // only called with the pipe empty
    task automatic write_tolerance(input logic [swn_pkg::TOL_W-1:0] t);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tol_now = t;
    endtask

    // Output side: check every word taken, then pick ready for the next edge.
    // Two long hold-offs let the pipe fill and push back on the input.
    always @(posedge i_clk) begin
        t_norm_res want;
        logic [swn_pkg::W_W-1:0] got [4];
        logic rdy;
        int r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got[0] = o_weight_out_0;
                got[1] = o_weight_out_1;
                got[2] = o_weight_out_2;
                got[3] = o_weight_out_3;
                if (owed_q.size() == 0) begin
                    $error("result word taken with nothing expected");
                    err_cnt++;
                end else begin
                    want = owed_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got[i] !== want.w[i]) begin
                            $error("weight_out_%0d: expected %0d, got %0d",
                                   i, want.w[i], got[i]);
                            err_cnt++;
                        end
                    end
                    if (o_adjusted !== want.adj) begin
                        $error("adjusted: expected %0d, got %0d", want.adj, o_adjusted);
                        err_cnt++;
                    end
                end
                rx_taken++;
                if (rx_taken == 300 || rx_taken == 900)
                    rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rdy = 1'b0;
            end else if (rx_calm > 0) begin
                rx_calm--;
                rdy = 1'b1;
            end else begin
                r = $urandom_range(99, 0);
                rdy = 1'b0;
                if (r < 50) begin
                    rdy = 1'b1;
                end else if (r < 85) begin
                    rx_hold = $urandom_range(2, 0);
                end else if (r < 95) begin
                    rx_calm = $urandom_range(80, 20);
                    rdy = 1'b1;
                end else begin
                    rx_hold = $urandom_range(40, 8);
                end
            end
            i_out_ready <= rdy;
        end
    end

    initial begin
        t_vtx v;
        t_norm_res want;
        logic [swn_pkg::TOL_W-1:0] t;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tol_now = TOL_AFTER_RESET;
        @(posedge i_clk);

        // directed rows at the reset tolerance
        for (int k = 0; k < DIR_ROWS; k++) begin
            for (int i = 0; i < 4; i++)
                v[i] = swn_pkg::IN_W'(dir_tab[k][i]);
            if (dir_tab[k][4] == ROW_TYPED) begin
                for (int i = 0; i < 4; i++)
                    want.w[i] = swn_pkg::W_W'(dir_tab[k][5 + i]);
                want.adj = dir_tab[k][9][0];
            end else begin
                want = normalize_vertex(v, tol_now);
            end
            send_word(v, want);
        end

        // random phases, tolerance changed between them with the pipe empty
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       t = '0;
                1:       t = '1;
                2:       t = swn_pkg::TOL_W'($urandom_range(254, 2));
                3:       t = TOL_AFTER_RESET;
                default: t = swn_pkg::TOL_W'($urandom_range(255, 0));
            endcase
            write_tolerance(t);
            for (int n = 0; n < PHASE_LEN; n++) begin
                v = random_vertex(tol_now);
                send_word(v, normalize_vertex(v, tol_now));
            end
        end

        drain();
        // anything extra coming out late gets flagged by the output-side check
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0 && owed_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
